[design/lmotm_pkg.sv]
// lmotm_pkg: shared widths, matrix wiring tables, opcodes and the
// command/status types between the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package lmotm_pkg;

  localparam int PIN_W     = 32;
  localparam int OP_W      = 2;
  localparam int PIN_NUM_W = 5;
  localparam int TICK_W    = 32;
  localparam int LED_IDX_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam int ROW_BASE  = 13;
  localparam int COL_BASE  = 4;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_COLS  = 9;
  localparam int MAX_CELLS = 27;

  localparam logic [PIN_NUM_W-1:0] FRAME_PIN = 5'd15;

  localparam logic [1:0] CELL_ROW [MAX_CELLS] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1};
  localparam logic [3:0] CELL_COL [MAX_CELLS] = '{
    4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd1, 4'd8, 4'd2, 4'd8,
    4'd0, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd6, 4'd0, 4'd5, 4'd1, 4'd7, 4'd8};

  localparam logic [OP_W-1:0] OP_SET     = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_PIN = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LEVEL   = 1'b1;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_REFRESH,
    DP_CLOSE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic [LED_IDX_W-1:0] idx;
  } lmotm_cmd_t;

  typedef struct packed {
    logic in_event;
    logic frame_start;
    logic out_free;
  } lmotm_sts_t;

endpackage

[design/lmotm_if.sv]
// lmotm_if: valid/ready channel interfaces for pin events and led results
// depends on lmotm_pkg
`timescale 1ns / 1ps

interface lmotm_in_if import lmotm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [PIN_W-1:0]     pin_sel;
  logic [PIN_NUM_W-1:0] pin_id;
  logic [TICK_W-1:0]    now;

  modport source (output valid, opcode, pin_sel, pin_id, now, input ready);
  modport sink   (input valid, opcode, pin_sel, pin_id, now, output ready);
endinterface

interface lmotm_out_if import lmotm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LED_IDX_W-1:0] led_index;
  logic [TICK_W-1:0]    brightness;
  logic                 last;

  modport source (output valid, led_index, brightness, last, input ready);
  modport sink   (input valid, led_index, brightness, last, output ready);
endinterface

[design/led_matrix_on_time_meter_top.sv]
// Led matrix on-time meter, top level.
// Channels: in_chan takes pin event words (opcode, pin_sel, pin_id, now);
// out_chan gives led result words (led_index, brightness, last); both are
// valid/ready, a word moves when valid and ready are high at a clock edge.
// cfg_we/cfg_index/cfg_wdata write output_enable (index 0) or input_level
// (index 1); the user writes only while the block is idle, not enforced.
// Sequence: a set/clear event is accepted, then all led states are
// refreshed in parallel; an opcode 3 word is accepted with no refresh. A
// frame start adds a close step and then drains NUM_LEDS results, one per
// cycle while the receiver takes them, the first one emitted after the
// accept, refresh and close steps. The controller sequence bounds rate.
// A single output register holds the current result: when the receiver
// stalls, the drain waits and in_chan stays not ready until the last
// result of the frame is in the register.
// Reset (rst_n low, synchronous) clears pins, config, led states and
// accumulators and empties the output register.
// depends on lmotm_pkg, lmotm_if, lmotm_ctrl, lmotm_datapath
`timescale 1ns / 1ps

module led_matrix_on_time_meter_top import lmotm_pkg::*; #(
  parameter int NUM_LEDS = 25,
  parameter int NUM_PINS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIN_W-1:0]     cfg_wdata,
  lmotm_in_if.sink             in_chan,
  lmotm_out_if.source          out_chan
);

  lmotm_cmd_t cmd;
  lmotm_sts_t sts;

  lmotm_ctrl #(
    .NUM_LEDS (NUM_LEDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmotm_datapath #(
    .NUM_LEDS (NUM_LEDS),
    .NUM_PINS (NUM_PINS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_chan.opcode),
    .in_pin_sel     (in_chan.pin_sel),
    .in_pin_id      (in_chan.pin_id),
    .in_now         (in_chan.now),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_led_index  (out_chan.led_index),
    .out_brightness (out_chan.brightness),
    .out_last       (out_chan.last)
  );

endmodule

[design/lmotm_datapath.sv]
// lmotm_datapath: config registers, pin latch, per-led on-time accumulators
// and the result output register; driven by lmotm_ctrl commands
// depends on lmotm_pkg
`timescale 1ns / 1ps

module lmotm_datapath import lmotm_pkg::*; #(
  parameter int NUM_LEDS = 25,
  parameter int NUM_PINS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIN_W-1:0]     cfg_wdata,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [PIN_W-1:0]     in_pin_sel,
  input  logic [PIN_NUM_W-1:0] in_pin_id,
  input  logic [TICK_W-1:0]    in_now,
  input  lmotm_cmd_t           cmd,
  output lmotm_sts_t           sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LED_IDX_W-1:0] out_led_index,
  output logic [TICK_W-1:0]    out_brightness,
  output logic                 out_last
);

  logic [PIN_W-1:0]     oe_r;
  logic [PIN_W-1:0]     in_level_r;
  logic [PIN_W-1:0]     pin_out_r;
  logic [PIN_W-1:0]     pin_out_nxt;
  logic [OP_W-1:0]      op_r;
  logic [PIN_NUM_W-1:0] pin_r;
  logic [TICK_W-1:0]    now_r;

  logic [NUM_LEDS-1:0]  lit_r;
  logic [TICK_W-1:0]    since_r [NUM_LEDS];
  logic [TICK_W-1:0]    total_r [NUM_LEDS];

  logic                 out_valid_r;
  logic [LED_IDX_W-1:0] out_idx_r;
  logic [TICK_W-1:0]    out_bright_r;
  logic                 out_last_r;

  logic [PIN_W-1:0]     pin_range;
  logic [PIN_W-1:0]     mask_eff;
  logic [PIN_W-1:0]     wr_mask;
  logic [PIN_W-1:0]     level;
  logic [NUM_LEDS-1:0]  on;
  logic [TICK_W-1:0]    sum [NUM_LEDS];
  logic [TICK_W-1:0]    sel_total;
  logic                 sel_last;

  always_comb begin
    for (int p = 0; p < PIN_W; p++) begin
      pin_range[p] = (p < NUM_PINS);
    end
  end

  // pin write on accept
  always_comb begin
    mask_eff = (in_opcode == OP_CLR_PIN) ? (PIN_W'(1) << in_pin_id) : in_pin_sel;
    wr_mask  = mask_eff & pin_range & oe_r;
    case (in_opcode)
      OP_SET:  pin_out_nxt = pin_out_r | wr_mask;
      OP_NONE: pin_out_nxt = pin_out_r;
      default: pin_out_nxt = pin_out_r & ~wr_mask;
    endcase
  end

  assign level = (oe_r & pin_out_r) | (~oe_r & in_level_r);

  for (genvar k = 0; k < NUM_LEDS; k++) begin : g_led
    assign on[k]  = level[ROW_BASE + CELL_ROW[k]] & ~level[COL_BASE + CELL_COL[k]];
    assign sum[k] = total_r[k] + (now_r - since_r[k]);
  end

  always_comb begin
    sel_total = '0;
    for (int k = 0; k < NUM_LEDS; k++) begin
      if (cmd.idx == LED_IDX_W'(k)) begin
        sel_total = total_r[k];
      end
    end
    sel_last = (cmd.idx == LED_IDX_W'(NUM_LEDS - 1));
  end

  assign sts.in_event    = (in_opcode != OP_NONE);
  assign sts.frame_start = (op_r == OP_CLR_PIN) && (pin_r == FRAME_PIN)
                           && (&level[COL_BASE +: NUM_COLS])
                           && !(|level[ROW_BASE +: NUM_ROWS]);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oe_r       <= '0;
      in_level_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTPUT_ENABLE: oe_r       <= cfg_wdata;
        CFG_INPUT_LEVEL:   in_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_out_r <= '0;
    end else if (cmd.op == DP_LOAD) begin
      pin_out_r <= pin_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      op_r  <= in_opcode;
      pin_r <= in_pin_id;
      now_r <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= '0;
      for (int k = 0; k < NUM_LEDS; k++) begin
        since_r[k] <= '0;
        total_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_LEDS; k++) begin
        case (cmd.op)
          DP_REFRESH: begin
            if (on[k] != lit_r[k]) begin
              if (on[k]) begin
                since_r[k] <= now_r;
              end else begin
                total_r[k] <= sum[k];
              end
              lit_r[k] <= on[k];
            end
          end
          DP_CLOSE: begin
            if (lit_r[k]) begin
              total_r[k] <= sum[k];
              since_r[k] <= now_r;
            end
          end
          DP_EMIT: begin
            if (cmd.idx == LED_IDX_W'(k)) begin
              total_r[k] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      out_idx_r    <= cmd.idx;
      out_bright_r <= sel_total;
      out_last_r   <= sel_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_index  = out_idx_r;
  assign out_brightness = out_bright_r;
  assign out_last       = out_last_r;

endmodule

[design/lmotm_ctrl.sv]
// lmotm_ctrl: sequencer for event accept, led refresh, frame close and
// the per-led result drain
// depends on lmotm_pkg
`timescale 1ns / 1ps

module lmotm_ctrl import lmotm_pkg::*; #(
  parameter int NUM_LEDS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lmotm_sts_t sts,
  output lmotm_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REFRESH,
    S_CLOSE,
    S_DRAIN
  } state_t;

  state_t               state_r;
  logic [LED_IDX_W-1:0] idx_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.idx = idx_r;
    case (state_r)
      S_IDLE:    cmd.op = in_valid ? DP_LOAD : DP_NONE;
      S_REFRESH: cmd.op = DP_REFRESH;
      S_CLOSE:   cmd.op = DP_CLOSE;
      S_DRAIN:   cmd.op = sts.out_free ? DP_EMIT : DP_NONE;
      default:   cmd.op = DP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && sts.in_event) begin
            state_r <= S_REFRESH;
          end
        end
        S_REFRESH: begin
          state_r <= sts.frame_start ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          idx_r   <= '0;
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (sts.out_free) begin
            idx_r <= idx_r + LED_IDX_W'(1);
            if (idx_r == LED_IDX_W'(NUM_LEDS - 1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/lmotm_checker.sv]
// lmotm_checker: port-level assertions for the on-time meter, bound to
// led_matrix_on_time_meter_top
// depends on lmotm_pkg
`timescale 1ns / 1ps

module lmotm_checker import lmotm_pkg::*; #(
  parameter int NUM_LEDS = 25
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [OP_W-1:0]      in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LED_IDX_W-1:0] out_led_index,
  input logic [TICK_W-1:0]    out_brightness,
  input logic                 out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_led_index) && $stable(out_brightness) && $stable(out_last))
    else $error("result word changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_led_index == LED_IDX_W'(NUM_LEDS - 1))
    else $error("last flag on wrong led");

  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("event accepted in the middle of a frame drain");

  a_nop_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_NONE |=> in_ready)
    else $error("unused opcode kept the block busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_matrix_on_time_meter_top lmotm_checker #(
  .NUM_LEDS (NUM_LEDS)
) u_lmotm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_opcode      (in_chan.opcode),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_led_index  (out_chan.led_index),
  .out_brightness (out_chan.brightness),
  .out_last       (out_chan.last)
);
